@@ hw/rtl/ccond_pkg.sv @@
// shared types and constants of the control axis conditioner
package ccond_pkg;

   // operand and result widths of the serial arithmetic unit
   localparam int OPA_W = 31;
   localparam int OPB_W = 17;
   localparam int Y_W = 11;
   localparam int ACC_W = 42;
   localparam int Q_W = 14;
   localparam int DSR_W = OPB_W + Q_W - 1;
   localparam int CNT_W = 4;

   // curve divisor 256000000 is a shift by 11 then a divide by 125000
   localparam int CURVE_SHIFT = 11;
   localparam logic [OPB_W-1:0] CURVE_DIVISOR = 17'd125000;
   localparam logic [10:0] KILO = 11'd1000;
   localparam logic [29:0] MEGA = 30'd1000000;

   localparam logic [3:0] MODE_NONE = 4'd0;
   localparam logic [3:0] MODE_DEV_AXIS = 4'd1;
   localparam logic [3:0] MODE_DEV_BUTTON = 4'd2;
   localparam logic [3:0] MODE_DEV_HAT = 4'd3;
   localparam logic [3:0] MODE_DEV_KEY = 4'd4;
   localparam logic [3:0] MODE_KBD_AXIS = 4'd5;
   localparam logic [3:0] MODE_KBD_BUTTON = 4'd6;
   localparam logic [3:0] MODE_KBD_HAT = 4'd7;
   localparam logic [3:0] MODE_KBD_KEY = 4'd8;

   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_AXIS_MIN = 3'd1;
   localparam logic [2:0] REG_AXIS_MAX = 3'd2;
   localparam logic [2:0] REG_NEGATE = 3'd3;
   localparam logic [2:0] REG_RISE_STEP = 3'd4;
   localparam logic [2:0] REG_FALL_STEP = 3'd5;
   localparam logic [2:0] REG_LINEARITY = 3'd6;
   localparam logic [2:0] REG_HAT_TARGET = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRC,
      ST_AXMUL,
      ST_AXDIV,
      ST_CURVE,
      ST_SQ,
      ST_WGT,
      ST_INNER,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef enum logic {
      OP_MUL,
      OP_DIV
   } arith_op_type;

   typedef struct packed {
      logic start;
      arith_op_type op;
      logic [OPA_W-1:0] opa;
      logic [OPB_W-1:0] opb;
   } arith_cmd_type;

   typedef struct packed {
      logic busy;
      logic [ACC_W-1:0] product;
      logic [Q_W-1:0] quotient;
   } arith_stat_type;

endpackage

@@ hw/rtl/ccond_arith.sv @@
// bit-serial shift-add multiplier and restoring divider shared by all steps
module ccond_arith (
   input  logic clock,
   input  logic reset,
   input  ccond_pkg::arith_cmd_type cmd,
   output ccond_pkg::arith_stat_type stat
);

   logic [ccond_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [ccond_pkg::OPA_W-1:0] x_ff, x_in;
   logic [ccond_pkg::Y_W-1:0] y_ff, y_in;
   logic [ccond_pkg::OPA_W-1:0] rem_ff, rem_in;
   logic [ccond_pkg::DSR_W-1:0] dsr_ff, dsr_in;
   logic [ccond_pkg::Q_W-1:0] q_ff, q_in;
   logic [ccond_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   ccond_pkg::arith_op_type op_ff, op_in;

   always_comb begin
      acc_in = acc_ff;
      x_in = x_ff;
      y_in = y_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      op_in = op_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in = cmd.op;
         if (cmd.op == ccond_pkg::OP_MUL) begin
            acc_in = '0;
            x_in = cmd.opa;
            y_in = cmd.opb[ccond_pkg::Y_W-1:0];
            cnt_in = ccond_pkg::CNT_W'(ccond_pkg::Y_W - 1);
         end else begin
            rem_in = cmd.opa;
            dsr_in = {cmd.opb, {(ccond_pkg::Q_W-1){1'b0}}};
            q_in = '0;
            cnt_in = ccond_pkg::CNT_W'(ccond_pkg::Q_W - 1);
         end
      end else if (busy_ff) begin
         if (op_ff == ccond_pkg::OP_MUL) begin
            // msb first: one multiplier bit per cycle
            acc_in = {acc_ff[ccond_pkg::ACC_W-2:0], 1'b0}
               + (y_ff[ccond_pkg::Y_W-1]
                  ? {{(ccond_pkg::ACC_W-ccond_pkg::OPA_W){1'b0}}, x_ff}
                  : {ccond_pkg::ACC_W{1'b0}});
            y_in = {y_ff[ccond_pkg::Y_W-2:0], 1'b0};
         end else begin
            // one quotient bit per cycle
            if (rem_ff >= {1'b0, dsr_ff}) begin
               rem_in = rem_ff - {1'b0, dsr_ff};
               q_in = {q_ff[ccond_pkg::Q_W-2:0], 1'b1};
            end else begin
               q_in = {q_ff[ccond_pkg::Q_W-2:0], 1'b0};
            end
            dsr_in = {1'b0, dsr_ff[ccond_pkg::DSR_W-1:1]};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
         op_ff <= ccond_pkg::OP_MUL;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
         op_ff <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      x_ff <= x_in;
      y_ff <= y_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      q_ff <= q_in;
   end

   assign stat.busy = busy_ff;
   assign stat.product = acc_ff;
   assign stat.quotient = q_ff;

endmodule

@@ hw/rtl/control_axis_conditioner_top.sv @@
// control axis conditioner top level: source select, ramp, scaling and curve
//
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_axis_sample, req_pressed, req_hat_sample
// rsp       out        rsp_valid / rsp_stall   rsp_value
// csr       in/out     psel penable pwrite     paddr, pwdata, prdata, pready
//
// one word at a time; an axis that needs scaling adds a multiply and a divide in the
// bit-serial multiply/divide unit, and source none skips the arithmetic
// synchronous reset loads register defaults, clears ramp and last value; no clearing pass
// a new word is taken while the previous result waits in the output register
module control_axis_conditioner_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [10:0] req_axis_sample,
   input  logic req_pressed,
   input  logic [15:0] req_hat_sample,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [13:0] rsp_value,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [4:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);

   // configuration
   logic [3:0] mode_ff, mode_in;
   logic signed [10:0] axis_min_ff, axis_min_in;
   logic signed [10:0] axis_max_ff, axis_max_in;
   logic negate_ff, negate_in;
   logic [9:0] rise_step_ff, rise_step_in;
   logic [9:0] fall_step_ff, fall_step_in;
   logic [8:0] linearity_ff, linearity_in;
   logic [15:0] hat_target_ff, hat_target_in;
   logic csr_write;

   // control and state
   ccond_pkg::state_type state_ff, state_in;
   logic signed [11:0] key_ramp_ff, key_ramp_in;
   logic signed [13:0] last_value_ff, last_value_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [13:0] rsp_value_ff, rsp_value_in;

   // datapath
   logic signed [10:0] sample_ff, sample_in;
   logic pressed_ff, pressed_in;
   logic [15:0] hat_ff, hat_in;
   logic signed [11:0] v_ff, v_in;
   logic neg_ff, neg_in;
   logic signed [13:0] res_ff, res_in;

   logic req_accept;
   logic rsp_load;
   logic signed [12:0] lo13, hi13, kr_up, kr_dn, kr_new;
   logic signed [11:0] lo12, hi12, ax_in, clamped, ax_ofs, span;
   logic [10:0] dist_mag, span_mag;
   logic span_direct;
   logic signed [11:0] vraw;
   logic signed [11:0] v_abs;
   logic [10:0] m;
   logic signed [9:0] lw;
   logic [8:0] lw_mag;
   logic [29:0] lin_term;
   logic signed [32:0] s_val;
   logic [30:0] s_mag;
   logic [13:0] q;
   logic signed [14:0] q_neg;
   logic signed [13:0] res_sat;

   ccond_pkg::arith_cmd_type cmd;
   ccond_pkg::arith_stat_type stat;

   ccond_arith u_arith (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   // configuration port
   assign pready = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      mode_in = mode_ff;
      axis_min_in = axis_min_ff;
      axis_max_in = axis_max_ff;
      negate_in = negate_ff;
      rise_step_in = rise_step_ff;
      fall_step_in = fall_step_ff;
      linearity_in = linearity_ff;
      hat_target_in = hat_target_ff;
      if (csr_write) begin
         case (paddr[4:2])
            ccond_pkg::REG_MODE: mode_in = pwdata[3:0];
            ccond_pkg::REG_AXIS_MIN: axis_min_in = pwdata[10:0];
            ccond_pkg::REG_AXIS_MAX: axis_max_in = pwdata[10:0];
            ccond_pkg::REG_NEGATE: negate_in = pwdata[0];
            ccond_pkg::REG_RISE_STEP: rise_step_in = pwdata[9:0];
            ccond_pkg::REG_FALL_STEP: fall_step_in = pwdata[9:0];
            ccond_pkg::REG_LINEARITY: linearity_in = pwdata[8:0];
            ccond_pkg::REG_HAT_TARGET: hat_target_in = pwdata[15:0];
            default: mode_in = mode_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         ccond_pkg::REG_MODE: prdata = {28'b0, mode_ff};
         ccond_pkg::REG_AXIS_MIN: prdata = {21'b0, axis_min_ff};
         ccond_pkg::REG_AXIS_MAX: prdata = {21'b0, axis_max_ff};
         ccond_pkg::REG_NEGATE: prdata = {31'b0, negate_ff};
         ccond_pkg::REG_RISE_STEP: prdata = {22'b0, rise_step_ff};
         ccond_pkg::REG_FALL_STEP: prdata = {22'b0, fall_step_ff};
         ccond_pkg::REG_LINEARITY: prdata = {23'b0, linearity_ff};
         ccond_pkg::REG_HAT_TARGET: prdata = {16'b0, hat_target_ff};
         default: prdata = '0;
      endcase
   end

   // handshakes
   assign req_stall = (state_ff != ccond_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load = (state_ff == ccond_pkg::ST_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // keyboard ramp and axis clamp
   assign lo13 = {{2{axis_min_ff[10]}}, axis_min_ff};
   assign hi13 = {{2{axis_max_ff[10]}}, axis_max_ff};
   assign lo12 = lo13[11:0];
   assign hi12 = hi13[11:0];
   assign kr_up = $signed({key_ramp_ff[11], key_ramp_ff}) + $signed({3'b000, rise_step_ff});
   assign kr_dn = $signed({key_ramp_ff[11], key_ramp_ff}) - $signed({3'b000, fall_step_ff});
   assign kr_new = pressed_ff ? ((kr_up > hi13) ? hi13 : kr_up)
                              : ((kr_dn < lo13) ? lo13 : kr_dn);
   assign ax_in = (mode_ff == ccond_pkg::MODE_KBD_AXIS) ? kr_new[11:0]
                                                        : {sample_ff[10], sample_ff};
   assign clamped = (ax_in < lo12) ? lo12 : ((ax_in > hi12) ? hi12 : ax_in);
   assign ax_ofs = clamped - lo12;
   assign span = hi12 - lo12;
   assign dist_mag = ax_ofs[11] ? 11'(-ax_ofs) : ax_ofs[10:0];
   assign span_mag = span[11] ? 11'(-span) : span[10:0];
   assign span_direct = span inside {12'sd0, 12'sd1000};

   // curve operands
   assign v_abs = v_ff[11] ? -v_ff : v_ff;
   assign m = v_abs[10:0];
   assign lw = 10'sd256 - $signed({1'b0, linearity_ff});
   assign lw_mag = lw[9] ? 9'(-lw) : lw[8:0];
   assign lin_term = 30'(linearity_ff) * ccond_pkg::MEGA;
   assign s_val = lw[9] ? ($signed({3'b000, lin_term}) - $signed({2'b00, stat.product[30:0]}))
                        : ($signed({3'b000, lin_term}) + $signed({2'b00, stat.product[30:0]}));
   assign s_mag = s_val[32] ? 31'(-s_val) : s_val[30:0];

   // result sign and saturation
   assign q = stat.quotient;
   assign q_neg = -$signed({1'b0, q});
   always_comb begin
      if (!neg_ff) begin
         res_sat = (q > 14'd8191) ? 14'sd8191 : $signed({1'b0, q[12:0]});
      end else begin
         res_sat = (q > 14'd8192) ? $signed(14'h2000) : q_neg[13:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      key_ramp_in = key_ramp_ff;
      last_value_in = last_value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      sample_in = sample_ff;
      pressed_in = pressed_ff;
      hat_in = hat_ff;
      neg_in = neg_ff;
      res_in = res_ff;
      vraw = '0;
      v_in = v_ff;
      cmd.start = 1'b0;
      cmd.op = ccond_pkg::OP_MUL;
      cmd.opa = '0;
      cmd.opb = '0;
      case (state_ff)
         ccond_pkg::ST_IDLE: begin
            if (req_accept) begin
               sample_in = req_axis_sample;
               pressed_in = req_pressed;
               hat_in = req_hat_sample;
               state_in = ccond_pkg::ST_SRC;
            end
         end
         ccond_pkg::ST_SRC: begin
            state_in = ccond_pkg::ST_CURVE;
            case (mode_ff)
               ccond_pkg::MODE_DEV_AXIS, ccond_pkg::MODE_KBD_AXIS: begin
                  if (mode_ff == ccond_pkg::MODE_KBD_AXIS) begin
                     key_ramp_in = kr_new[11:0];
                  end
                  vraw = ax_ofs;
                  if (!span_direct) begin
                     cmd.start = 1'b1;
                     cmd.op = ccond_pkg::OP_MUL;
                     cmd.opa = ccond_pkg::OPA_W'(dist_mag);
                     cmd.opb = ccond_pkg::OPB_W'(ccond_pkg::KILO);
                     neg_in = ax_ofs[11] ^ span[11];
                     state_in = ccond_pkg::ST_AXMUL;
                  end
               end
               ccond_pkg::MODE_DEV_BUTTON: vraw = pressed_ff ? 12'sd1000 : 12'sd0;
               ccond_pkg::MODE_DEV_HAT: vraw = (hat_ff == hat_target_ff) ? 12'sd1000 : 12'sd0;
               ccond_pkg::MODE_DEV_KEY, ccond_pkg::MODE_KBD_HAT: vraw = 12'sd0;
               ccond_pkg::MODE_KBD_BUTTON: vraw = pressed_ff ? hi12 : lo12;
               ccond_pkg::MODE_KBD_KEY: vraw = pressed_ff ? hi12 : 12'sd0;
               default: begin
                  res_in = last_value_ff;
                  state_in = ccond_pkg::ST_FIN;
               end
            endcase
            v_in = negate_ff ? (12'sd1000 - vraw) : vraw;
         end
         ccond_pkg::ST_AXMUL: begin
            if (!stat.busy) begin
               cmd.start = 1'b1;
               cmd.op = ccond_pkg::OP_DIV;
               cmd.opa = stat.product[ccond_pkg::OPA_W-1:0];
               cmd.opb = ccond_pkg::OPB_W'(span_mag);
               state_in = ccond_pkg::ST_AXDIV;
            end
         end
         ccond_pkg::ST_AXDIV: begin
            if (!stat.busy) begin
               vraw = neg_ff ? -$signed({2'b00, q[9:0]}) : $signed({2'b00, q[9:0]});
               v_in = negate_ff ? (12'sd1000 - vraw) : vraw;
               state_in = ccond_pkg::ST_CURVE;
            end
         end
         ccond_pkg::ST_CURVE: begin
            // v squared
            cmd.start = 1'b1;
            cmd.op = ccond_pkg::OP_MUL;
            cmd.opa = ccond_pkg::OPA_W'(m);
            cmd.opb = ccond_pkg::OPB_W'(m);
            state_in = ccond_pkg::ST_SQ;
         end
         ccond_pkg::ST_SQ: begin
            if (!stat.busy) begin
               // cubic weight times v squared
               cmd.start = 1'b1;
               cmd.op = ccond_pkg::OP_MUL;
               cmd.opa = ccond_pkg::OPA_W'(stat.product[21:0]);
               cmd.opb = ccond_pkg::OPB_W'(lw_mag);
               state_in = ccond_pkg::ST_WGT;
            end
         end
         ccond_pkg::ST_WGT: begin
            if (!stat.busy) begin
               // (linear term plus cubic term) times v
               cmd.start = 1'b1;
               cmd.op = ccond_pkg::OP_MUL;
               cmd.opa = s_mag;
               cmd.opb = ccond_pkg::OPB_W'(m);
               neg_in = v_ff[11] ^ s_val[32];
               state_in = ccond_pkg::ST_INNER;
            end
         end
         ccond_pkg::ST_INNER: begin
            if (!stat.busy) begin
               cmd.start = 1'b1;
               cmd.op = ccond_pkg::OP_DIV;
               cmd.opa = stat.product[ccond_pkg::ACC_W-1:ccond_pkg::CURVE_SHIFT];
               cmd.opb = ccond_pkg::CURVE_DIVISOR;
               state_in = ccond_pkg::ST_DIV;
            end
         end
         ccond_pkg::ST_DIV: begin
            if (!stat.busy) begin
               res_in = res_sat;
               state_in = ccond_pkg::ST_FIN;
            end
         end
         ccond_pkg::ST_FIN: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               last_value_in = res_ff;
               state_in = ccond_pkg::ST_IDLE;
            end
         end
         default: state_in = ccond_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ccond_pkg::ST_IDLE;
         key_ramp_ff <= '0;
         last_value_ff <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff <= ccond_pkg::MODE_NONE;
         axis_min_ff <= 11'sd0;
         axis_max_ff <= 11'sd1000;
         negate_ff <= 1'b0;
         rise_step_ff <= 10'd5;
         fall_step_ff <= 10'd50;
         linearity_ff <= 9'd256;
         hat_target_ff <= 16'd0;
      end else begin
         state_ff <= state_in;
         key_ramp_ff <= key_ramp_in;
         last_value_ff <= last_value_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff <= mode_in;
         axis_min_ff <= axis_min_in;
         axis_max_ff <= axis_max_in;
         negate_ff <= negate_in;
         rise_step_ff <= rise_step_in;
         fall_step_ff <= fall_step_in;
         linearity_ff <= linearity_in;
         hat_target_ff <= hat_target_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      sample_ff <= sample_in;
      pressed_ff <= pressed_in;
      hat_ff <= hat_in;
      v_ff <= v_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   // the shared unit is never restarted while running
   assert property (@(posedge clock) disable iff (reset) cmd.start |-> !stat.busy)
      else $error("arith unit started while busy");

   // a delivered word always matches the stored last value
   assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (rsp_value_ff == last_value_ff))
      else $error("output word differs from last value");

   // the ramp only moves while a word is being sourced
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(key_ramp_ff)) |-> $past(state_ff == ccond_pkg::ST_SRC))
      else $error("key ramp changed outside source step");

endmodule

@@ verif/control_axis_conditioner_top_test.sv @@
// self-checking testbench of the control axis conditioner top level
`timescale 1ns / 100ps

module control_axis_conditioner_top_test;

   class conditioner_scoreboard;
      logic [3:0] mode_reg;
      logic signed [10:0] min_reg;
      logic signed [10:0] max_reg;
      logic negate_reg;
      logic [9:0] rise_reg;
      logic [9:0] fall_reg;
      logic [8:0] lin_reg;
      logic [15:0] target_reg;
      int ramp;
      logic signed [13:0] last_value;
      logic signed [13:0] pending_values[$];
      int mismatches;

      function void clear();
         mode_reg = ccond_pkg::MODE_NONE;
         min_reg = '0;
         max_reg = 11'sd1000;
         negate_reg = 1'b0;
         rise_reg = 10'd5;
         fall_reg = 10'd50;
         lin_reg = 9'd256;
         target_reg = '0;
         ramp = 0;
         last_value = '0;
         pending_values.delete();
         mismatches = 0;
      endfunction

      function void set_register(logic [2:0] index, logic [31:0] data);
         case (index)
            ccond_pkg::REG_MODE: mode_reg = data[3:0];
            ccond_pkg::REG_AXIS_MIN: min_reg = data[10:0];
            ccond_pkg::REG_AXIS_MAX: max_reg = data[10:0];
            ccond_pkg::REG_NEGATE: negate_reg = data[0];
            ccond_pkg::REG_RISE_STEP: rise_reg = data[9:0];
            ccond_pkg::REG_FALL_STEP: fall_reg = data[9:0];
            ccond_pkg::REG_LINEARITY: lin_reg = data[8:0];
            default: target_reg = data[15:0];
         endcase
      endfunction

      function int scale_axis(int v);
         int lo;
         int hi;
         int span;
         lo = min_reg;
         hi = max_reg;
         span = hi - lo;
         if (v < lo) v = lo;
         else if (v > hi) v = hi;
         v = v - lo;
         if (span != 1000 && span != 0) v = (v * 1000) / span;
         return v;
      endfunction

      function void note_word(logic signed [10:0] sample, logic pressed, logic [15:0] hat);
         int v;
         longint lv;
         longint lin;
         longint num;
         longint res;
         v = 0;
         if (mode_reg == ccond_pkg::MODE_NONE || mode_reg > ccond_pkg::MODE_KBD_KEY) begin
            pending_values.push_back(last_value);
            return;
         end
         case (mode_reg)
            ccond_pkg::MODE_DEV_AXIS: v = scale_axis(sample);
            ccond_pkg::MODE_DEV_BUTTON: v = pressed ? 1000 : 0;
            ccond_pkg::MODE_DEV_HAT: v = (hat == target_reg) ? 1000 : 0;
            ccond_pkg::MODE_KBD_AXIS: begin
               if (pressed) begin
                  ramp = ramp + rise_reg;
                  if (ramp > max_reg) ramp = max_reg;
               end else begin
                  ramp = ramp - fall_reg;
                  if (ramp < min_reg) ramp = min_reg;
               end
               v = scale_axis(ramp);
            end
            ccond_pkg::MODE_KBD_BUTTON: v = pressed ? int'(max_reg) : int'(min_reg);
            ccond_pkg::MODE_KBD_KEY: v = pressed ? int'(max_reg) : 0;
            default: v = 0;
         endcase
         if (negate_reg) v = 1000 - v;
         lv = v;
         lin = lin_reg;
         num = lin * lv * 1000000 + (256 - lin) * lv * lv * lv;
         res = num / 256000000;
         if (res > 8191) res = 8191;
         if (res < -8192) res = -8192;
         last_value = res[13:0];
         pending_values.push_back(last_value);
      endfunction

      function void check_word(logic signed [13:0] actual);
         logic signed [13:0] expected;
         if (pending_values.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: value %0d", actual);
            return;
         end
         expected = pending_values.pop_front();
         if (actual !== expected) begin
            mismatches++;
            if (mismatches <= 10)
               $display("value mismatch: expected %0d actual %0d", expected, actual);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [10:0] req_axis_sample;
   logic req_pressed;
   logic [15:0] req_hat_sample;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [13:0] rsp_value;
   logic psel;
   logic penable;
   logic pwrite;
   logic [4:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   conditioner_scoreboard board;
   bit rsp_quiet;
   bit long_hold;
   bit req_quiet;

   control_axis_conditioner_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_axis_sample(req_axis_sample), .req_pressed(req_pressed),
      .req_hat_sample(req_hat_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_value(rsp_value),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #40ms;
      $display("Verification failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note_word(req_axis_sample, req_pressed, req_hat_sample);
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word(rsp_value);
   end

   // receiver stall pattern
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            long_hold = 0;
            rsp_stall <= 1'b0;
         end else if (!rsp_quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_word(logic signed [10:0] sample, logic pressed, logic [15:0] hat);
      if (!req_quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_axis_sample <= sample;
      req_pressed <= pressed;
      req_hat_sample <= hat;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_wait();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_values.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] index, logic [31:0] data);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {index, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      board.set_register(index, data);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic random_word();
      logic signed [10:0] sample;
      logic [15:0] hat;
      case ($urandom_range(0, 3))
         0: sample = 11'($urandom);
         1: sample = board.min_reg + $signed(11'($urandom_range(0, 6)) - 11'sd3);
         2: sample = board.max_reg + $signed(11'($urandom_range(0, 6)) - 11'sd3);
         default: sample = $signed(11'($urandom_range(0, 2000))) - 11'sd1000;
      endcase
      hat = ($urandom_range(0, 1) == 0) ? board.target_reg : 16'($urandom);
      send_word(sample, ($urandom_range(0, 2) != 0) == ($urandom_range(0, 1) == 0), hat);
   endtask

   task automatic random_setup(bit extreme);
      logic [31:0] lo;
      logic [31:0] hi;
      lo = extreme ? 32'h7FF & (-1000) : $urandom;
      hi = extreme ? 32'd1000 : $urandom;
      if ($urandom_range(0, 3) != 0) begin
         lo = 32'h7FF & ($urandom_range(0, 2000) - 1000);
         hi = 32'h7FF & ($urandom_range(0, 2000) - 1000);
      end
      write_reg(ccond_pkg::REG_MODE,
                ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 8));
      write_reg(ccond_pkg::REG_AXIS_MIN, lo);
      write_reg(ccond_pkg::REG_AXIS_MAX, hi);
      write_reg(ccond_pkg::REG_NEGATE, $urandom);
      write_reg(ccond_pkg::REG_RISE_STEP, extreme ? 32'h3FF : $urandom);
      write_reg(ccond_pkg::REG_FALL_STEP, extreme ? 32'd0 : $urandom);
      case ($urandom_range(0, 4))
         0: write_reg(ccond_pkg::REG_LINEARITY, 32'd0);
         1: write_reg(ccond_pkg::REG_LINEARITY, 32'd256);
         2: write_reg(ccond_pkg::REG_LINEARITY, 32'h1FF);
         default: write_reg(ccond_pkg::REG_LINEARITY, $urandom);
      endcase
      write_reg(ccond_pkg::REG_HAT_TARGET, extreme ? 32'hFFFF : $urandom);
   endtask

   initial begin
      int wait_count;
      board = new();
      board.clear();
      reset = 1'b1;
      req_valid = 1'b0;
      req_axis_sample = '0;
      req_pressed = 1'b0;
      req_hat_sample = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      rsp_quiet = 0;
      req_quiet = 0;
      long_hold = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // source none after reset
      send_word(11'sd500, 1'b1, 16'hFFFF);
      idle_wait();
      // device axis, full scale and out of range samples
      write_reg(ccond_pkg::REG_MODE, 32'(ccond_pkg::MODE_DEV_AXIS));
      write_reg(ccond_pkg::REG_AXIS_MIN, 32'h7FF & (-1000));
      send_word($signed(11'h400), 1'b0, 16'h0000);
      send_word(11'sd1023, 1'b1, 16'hFFFF);
      send_word(11'sd0, 1'b0, 16'h0000);
      idle_wait();
      // zero range, inverted limits
      write_reg(ccond_pkg::REG_AXIS_MIN, 32'd300);
      write_reg(ccond_pkg::REG_AXIS_MAX, 32'd300);
      send_word(11'sd700, 1'b0, 16'h0000);
      idle_wait();
      write_reg(ccond_pkg::REG_AXIS_MIN, 32'd500);
      write_reg(ccond_pkg::REG_AXIS_MAX, 32'h7FF & (-500));
      send_word(11'sd600, 1'b0, 16'h0000);
      send_word(11'sd0, 1'b0, 16'h0000);
      send_word(-11'sd600, 1'b0, 16'h0000);
      idle_wait();
      write_reg(ccond_pkg::REG_AXIS_MIN, 32'h7FF & (-1000));
      write_reg(ccond_pkg::REG_AXIS_MAX, 32'd1000);
      write_reg(ccond_pkg::REG_HAT_TARGET, 32'hFFFF);
      write_reg(ccond_pkg::REG_MODE, 32'(ccond_pkg::MODE_DEV_BUTTON));
      send_word(11'sd0, 1'b1, 16'h0000);
      send_word(11'sd0, 1'b0, 16'h0000);
      idle_wait();
      write_reg(ccond_pkg::REG_MODE, 32'(ccond_pkg::MODE_DEV_HAT));
      send_word(11'sd0, 1'b0, 16'hFFFF);
      send_word(11'sd0, 1'b0, 16'h0000);
      idle_wait();
      write_reg(ccond_pkg::REG_MODE, 32'(ccond_pkg::MODE_DEV_KEY));
      write_reg(ccond_pkg::REG_NEGATE, 32'd1);
      send_word(11'sd0, 1'b1, 16'h0000);
      idle_wait();
      write_reg(ccond_pkg::REG_MODE, 32'(ccond_pkg::MODE_KBD_AXIS));
      write_reg(ccond_pkg::REG_RISE_STEP, 32'h3FF);
      write_reg(ccond_pkg::REG_FALL_STEP, 32'd0);
      send_word(11'sd0, 1'b1, 16'h0000);
      send_word(11'sd0, 1'b0, 16'h0000);
      idle_wait();
      write_reg(ccond_pkg::REG_MODE, 32'(ccond_pkg::MODE_KBD_BUTTON));
      write_reg(ccond_pkg::REG_LINEARITY, 32'd0);
      send_word(11'sd0, 1'b1, 16'h0000);
      send_word(11'sd0, 1'b0, 16'h0000);
      idle_wait();
      write_reg(ccond_pkg::REG_MODE, 32'(ccond_pkg::MODE_KBD_HAT));
      write_reg(ccond_pkg::REG_LINEARITY, 32'h1FF);
      send_word(11'sd0, 1'b1, 16'hFFFF);
      idle_wait();
      write_reg(ccond_pkg::REG_MODE, 32'(ccond_pkg::MODE_KBD_KEY));
      send_word(11'sd0, 1'b1, 16'h0000);
      send_word(11'sd0, 1'b0, 16'h0000);
      idle_wait();
      write_reg(ccond_pkg::REG_MODE, 32'd15);
      send_word(11'sd0, 1'b1, 16'h0000);
      idle_wait();

      // the last phases share one setup and run with no idling
      for (int phase = 0; phase < 20; phase++) begin
         if (phase <= 17) random_setup(phase == 0 || phase == 10);
         if (phase == 5) long_hold = 1;
         if (phase >= 17) begin
            rsp_quiet = 1;
            req_quiet = 1;
         end
         repeat (100) random_word();
         if (phase < 17) idle_wait();
      end
      req_valid <= 1'b0;

      wait_count = 0;
      while (board.pending_values.size() != 0 && wait_count < 10000) begin
         @(posedge clock);
         wait_count++;
      end
      repeat (200) @(posedge clock);
      if (board.mismatches == 0 && board.pending_values.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ control_axis_conditioner_top.f @@
hw/rtl/ccond_pkg.sv
hw/rtl/ccond_arith.sv
hw/rtl/control_axis_conditioner_top.sv
verif/control_axis_conditioner_top_test.sv
